// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/orc_pkg.sv =====
package orc_pkg;

    localparam int MAX_OBJECTS_DEF = 64;
    localparam int ID_W            = 64;
    localparam int ADDR_W          = 64;
    localparam int SIZE_W          = 64;
    localparam int STAMP_W         = 32;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_CLASSIFY = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_DUP     = 3'd1,
        STAT_NOMATCH = 3'd2,
        STAT_INVALID = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } orc_state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ADDR_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic               cls;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Per-entry verdict of the compare unit.
    typedef struct packed {
        logic               id_hit;
        logic               pair_hit;
        logic               range_hit;
        logic               empty;
        logic [STAMP_W-1:0] age;
        logic               cls;
    } cmp_res_t;

    function automatic int idx_width(input int n);
        int w;
        w = (n > 1) ? $clog2(n) : 1;
        return w;
    endfunction

endpackage

// ===== rtl/orc_table.sv =====
module orc_table #(
    parameter int MAX_OBJECTS = orc_pkg::MAX_OBJECTS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        rd_en,
    input  logic [orc_pkg::idx_width(MAX_OBJECTS)-1:0]  rd_idx,
    output orc_pkg::entry_t                             rd_entry,
    output logic                                        rd_valid,
    input  logic                                        wr_en,
    input  logic [orc_pkg::idx_width(MAX_OBJECTS)-1:0]  wr_idx,
    input  orc_pkg::entry_t                             wr_entry,
    input  logic                                        inv_en,
    input  logic [orc_pkg::idx_width(MAX_OBJECTS)-1:0]  inv_idx,
    input  logic                                        clear_all
);

    logic [MAX_OBJECTS-1:0] valid_reg;
    logic [MAX_OBJECTS-1:0] valid_next;
    orc_pkg::entry_t        entry_mem [MAX_OBJECTS];
    orc_pkg::entry_t        rd_entry_reg;
    logic                   rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear_all)
        begin
            valid_next = '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_next[wr_idx] = 1'b1;
            end
            if (inv_en)
            begin
                valid_next[inv_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    // Entry storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== rtl/orc_cmp.sv =====
module orc_cmp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_v,
    input  orc_pkg::entry_t                 entry,
    input  logic                            entry_valid,
    input  logic [orc_pkg::ID_W-1:0]        key_id,
    input  logic [orc_pkg::ADDR_W-1:0]      key_addr,
    input  logic [orc_pkg::STAMP_W-1:0]     counter,
    output logic                            out_v,
    output orc_pkg::cmp_res_t               res
);

    logic [orc_pkg::ADDR_W:0]        sub_full;

    logic                            a_v_reg;
    logic                            a_valid_reg;
    logic                            a_id_eq_reg;
    logic                            a_base_eq_reg;
    logic                            a_below_reg;
    logic [orc_pkg::ADDR_W-1:0]      a_diff_reg;
    logic [orc_pkg::SIZE_W-1:0]      a_size_reg;
    logic [orc_pkg::STAMP_W-1:0]     a_age_reg;
    logic                            a_cls_reg;

    logic                            b_v_reg;
    orc_pkg::cmp_res_t               res_reg;
    orc_pkg::cmp_res_t               res_next;

    // The borrow out of the subtraction says the address lies below the base.
    assign sub_full = {1'b0, key_addr} - {1'b0, entry.base};

    always_comb
    begin
        res_next.id_hit    = a_valid_reg & a_id_eq_reg;
        res_next.pair_hit  = a_valid_reg & a_id_eq_reg & a_base_eq_reg;
        res_next.range_hit = a_valid_reg & ~a_below_reg & (a_diff_reg < a_size_reg);
        res_next.empty     = ~a_valid_reg;
        res_next.age       = a_age_reg;
        res_next.cls       = a_cls_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= in_v;
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_valid_reg   <= entry_valid;
        a_id_eq_reg   <= (entry.id == key_id);
        a_base_eq_reg <= (entry.base == key_addr);
        a_below_reg   <= sub_full[orc_pkg::ADDR_W];
        a_diff_reg    <= sub_full[orc_pkg::ADDR_W-1:0];
        a_size_reg    <= entry.size;
        a_age_reg     <= counter - entry.stamp;
        a_cls_reg     <= entry.cls;
        res_reg       <= res_next;
    end

    assign out_v = b_v_reg;
    assign res   = res_reg;

endmodule

// ===== rtl/object_region_classifier_core.sv =====
// Allocate, free and classify scan the table before the done strobe, one entry per cycle
// through the single read port and the compare unit; clear and a malformed allocate skip
// the scan and go straight to finish. A new word is accepted in the cycle that done is high.
// The receiver cannot stall, so done lasts exactly one cycle.
// Reset empties the table and zeroes the allocation counter at once; no clearing pass runs.
`include "assert_macros.svh"

module object_region_classifier_core #(
    parameter int MAX_OBJECTS = orc_pkg::MAX_OBJECTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [1:0]                      command,
    input  logic [orc_pkg::ID_W-1:0]        obj_ident,
    input  logic [orc_pkg::ADDR_W-1:0]      address,
    input  logic [orc_pkg::SIZE_W-1:0]      size,
    input  logic                            region_class,
    output logic                            busy,
    output logic                            done,
    output logic                            class_out,
    output logic [2:0]                      status
);

    localparam int IDX_W = orc_pkg::idx_width(MAX_OBJECTS);
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OBJECTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_OBJECTS);

    // Sequencer state.
    orc_pkg::orc_state_t            state_reg;
    orc_pkg::orc_state_t            state_next;

    // The word under work is held here for the whole scan.
    orc_pkg::cmd_t                  cmd_reg;
    logic [orc_pkg::ID_W-1:0]       id_reg;
    logic [orc_pkg::ADDR_W-1:0]     addr_reg;
    logic [orc_pkg::SIZE_W-1:0]     size_reg;
    logic                           cls_reg;
    logic                           invalid_reg;

    // Scan counters: one counts reads issued, the other verdicts folded in.
    logic [CNT_W-1:0]               issue_cnt_reg;
    logic [CNT_W-1:0]               issue_cnt_next;
    logic [CNT_W-1:0]               acc_cnt_reg;
    logic [CNT_W-1:0]               acc_cnt_next;
    logic                           p1_reg;

    // Running results of the scan.
    logic                           dup_reg;
    logic                           slot_found_reg;
    logic [IDX_W-1:0]               slot_idx_reg;
    logic                           match_found_reg;
    logic [IDX_W-1:0]               match_idx_reg;
    logic                           best_found_reg;
    logic [orc_pkg::STAMP_W-1:0]    best_age_reg;
    logic                           best_cls_reg;

    logic [orc_pkg::STAMP_W-1:0]    counter_reg;
    logic [orc_pkg::STAMP_W-1:0]    counter_next;

    logic                           done_reg;
    logic                           class_reg;
    orc_pkg::status_t               status_reg;

    // Sequencer outputs.
    logic                           rd_en;
    logic                           wr_en;
    logic                           inv_en;
    logic                           clear_all;
    orc_pkg::status_t               fin_status;
    logic                           fin_class;

    logic                           accept;
    orc_pkg::cmd_t                  cmd_in;
    logic [orc_pkg::ADDR_W:0]       end_sum;
    logic                           invalid_in;
    logic [IDX_W-1:0]               acc_idx;

    orc_pkg::entry_t                rd_entry;
    logic                           rd_valid;
    orc_pkg::entry_t                wr_entry;
    logic                           res_v;
    orc_pkg::cmp_res_t              res;

    assign accept = start && (state_reg == orc_pkg::ST_IDLE);
    assign cmd_in = orc_pkg::cmd_t'(command);

    // A range that would run past the top of the address space carries out of this add.
    assign end_sum    = {1'b0, address} + {1'b0, size};
    assign invalid_in = (obj_ident == '0) || (address == '0) || (size == '0)
                        || end_sum[orc_pkg::ADDR_W];

    assign acc_idx  = acc_cnt_reg[IDX_W-1:0];
    assign wr_entry = '{id: id_reg, base: addr_reg, size: size_reg, cls: cls_reg,
                        stamp: counter_reg};

    // Table storage with its valid bits.
    orc_table #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_idx    (issue_cnt_reg[IDX_W-1:0]),
        .rd_entry  (rd_entry),
        .rd_valid  (rd_valid),
        .wr_en     (wr_en),
        .wr_idx    (slot_idx_reg),
        .wr_entry  (wr_entry),
        .inv_en    (inv_en),
        .inv_idx   (match_idx_reg),
        .clear_all (clear_all)
    );

    // Shared compare unit: every entry read passes through it, two stages deep.
    orc_cmp u_cmp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_v        (p1_reg),
        .entry       (rd_entry),
        .entry_valid (rd_valid),
        .key_id      (id_reg),
        .key_addr    (addr_reg),
        .counter     (counter_reg),
        .out_v       (res_v),
        .res         (res)
    );

    // Next state. Clear and a malformed allocate need no scan and go straight to finish.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            orc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if ((cmd_in == orc_pkg::CMD_ALLOC && !invalid_in)
                        || (cmd_in inside {orc_pkg::CMD_FREE, orc_pkg::CMD_CLASSIFY}))
                    begin
                        state_next = orc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = orc_pkg::ST_FINISH;
                    end
                end
            end
            orc_pkg::ST_SCAN:
            begin
                // Leave once the verdict for the last entry has been folded in.
                if (res_v && (acc_cnt_reg == CNT_LAST))
                begin
                    state_next = orc_pkg::ST_FINISH;
                end
            end
            orc_pkg::ST_FINISH:
            begin
                state_next = orc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = orc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. In finish the scan results decide the status and the single
    // table update; the allocate checks keep their order: malformed, duplicate, full.
    always_comb
    begin
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        inv_en       = 1'b0;
        clear_all    = 1'b0;
        fin_status   = orc_pkg::STAT_OK;
        fin_class    = 1'b0;
        counter_next = counter_reg;
        case (state_reg)
            orc_pkg::ST_SCAN:
            begin
                rd_en = (issue_cnt_reg != CNT_FULL);
            end
            orc_pkg::ST_FINISH:
            begin
                case (cmd_reg)
                    orc_pkg::CMD_ALLOC:
                    begin
                        if (invalid_reg)
                        begin
                            fin_status = orc_pkg::STAT_INVALID;
                        end
                        else if (dup_reg)
                        begin
                            fin_status = orc_pkg::STAT_DUP;
                        end
                        else if (!slot_found_reg)
                        begin
                            fin_status = orc_pkg::STAT_FULL;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            counter_next = counter_reg + 1'b1;
                        end
                    end
                    orc_pkg::CMD_FREE:
                    begin
                        if (match_found_reg)
                        begin
                            inv_en = 1'b1;
                        end
                        else
                        begin
                            fin_status = orc_pkg::STAT_NOMATCH;
                        end
                    end
                    orc_pkg::CMD_CLASSIFY:
                    begin
                        fin_class = best_found_reg & best_cls_reg;
                    end
                    orc_pkg::CMD_CLEAR:
                    begin
                        clear_all    = 1'b1;
                        counter_next = '0;
                    end
                    default:
                    begin
                        fin_status = orc_pkg::STAT_OK;
                    end
                endcase
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        issue_cnt_next = issue_cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        if (accept)
        begin
            issue_cnt_next = '0;
            acc_cnt_next   = '0;
        end
        else
        begin
            if (rd_en)
            begin
                issue_cnt_next = issue_cnt_reg + 1'b1;
            end
            if (res_v)
            begin
                acc_cnt_next = acc_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= orc_pkg::ST_IDLE;
            issue_cnt_reg <= '0;
            acc_cnt_reg   <= '0;
            p1_reg        <= 1'b0;
            counter_reg   <= '0;
            done_reg      <= 1'b0;
            class_reg     <= 1'b0;
            status_reg    <= orc_pkg::STAT_OK;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
            p1_reg        <= rd_en;
            counter_reg   <= counter_next;
            done_reg      <= (state_reg == orc_pkg::ST_FINISH);
            if (state_reg == orc_pkg::ST_FINISH)
            begin
                class_reg  <= fin_class;
                status_reg <= fin_status;
            end
        end
    end

    // Fold each entry verdict into the running results. Entries arrive in index order,
    // so the first empty entry and the first id/base match are the lowest-numbered ones.
    // The nearest stamp wins among range hits; a tie keeps the earlier entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_reg         <= 1'b0;
            slot_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            best_cls_reg    <= 1'b0;
        end
        else if (accept)
        begin
            dup_reg         <= 1'b0;
            slot_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            best_cls_reg    <= 1'b0;
        end
        else if (res_v)
        begin
            if (res.id_hit)
            begin
                dup_reg <= 1'b1;
            end
            if (res.empty && !slot_found_reg)
            begin
                slot_found_reg <= 1'b1;
            end
            if (res.pair_hit && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
            end
            if (res.range_hit && (!best_found_reg || (res.age < best_age_reg)))
            begin
                best_found_reg <= 1'b1;
                best_cls_reg   <= res.cls;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_in;
            id_reg      <= obj_ident;
            addr_reg    <= address;
            size_reg    <= size;
            cls_reg     <= region_class;
            invalid_reg <= invalid_in;
        end
        if (res_v)
        begin
            if (res.empty && !slot_found_reg)
            begin
                slot_idx_reg <= acc_idx;
            end
            if (res.pair_hit && !match_found_reg)
            begin
                match_idx_reg <= acc_idx;
            end
            if (res.range_hit && (!best_found_reg || (res.age < best_age_reg)))
            begin
                best_age_reg <= res.age;
            end
        end
    end

    assign busy      = (state_reg != orc_pkg::ST_IDLE);
    assign done      = done_reg;
    assign class_out = class_reg;
    assign status    = status_reg;

    // The finish state always produces exactly one strobe and returns to idle.
    `ASSERT_NEXT(a_finish_strobes, clk, rst_n, state_reg == orc_pkg::ST_FINISH,
                 done_reg && (state_reg == orc_pkg::ST_IDLE))
    // An accepted word makes the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // The scan never folds in more verdicts than reads it has issued.
    `ASSERT_IMPLIES(a_scan_order, clk, rst_n, state_reg == orc_pkg::ST_SCAN,
                    acc_cnt_reg <= issue_cnt_reg)
    // Classify and clear never report an error.
    `ASSERT_IMPLIES(a_status_ok, clk, rst_n,
                    done_reg && (cmd_reg == orc_pkg::CMD_CLASSIFY
                                 || cmd_reg == orc_pkg::CMD_CLEAR),
                    status_reg == orc_pkg::STAT_OK)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // One word as the sender presents it. A word may carry a typed-in result
    // (pinned) for the directed rows whose outcome is obvious; every other word
    // is checked against the table model below.
    typedef struct {
        orc_pkg::cmd_t    cmd;
        logic [63:0]      id;
        logic [63:0]      addr;
        logic [63:0]      size;
        logic             cls;
        bit               pinned;
        logic             pin_cls;
        orc_pkg::status_t pin_st;
    } stim_row_t;

    typedef struct {
        logic             cls;
        orc_pkg::status_t st;
    } region_result_t;

    // An object the sender has tried to allocate. It is used to build frees
    // and lookups that actually hit something. Entries can be stale, which
    // only yields extra unmatched frees and misses.
    typedef struct {
        logic [63:0] id;
        logic [63:0] base;
        logic [63:0] size;
    } obj_ref_t;

    localparam int N_OBJ        = orc_pkg::MAX_OBJECTS_DEF;
    localparam int RANDOM_WORDS = 1425;
    localparam int QUIET_TAIL   = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    stim_row_t cur_word;

    logic       busy;
    logic       done;
    logic       class_out;
    logic [2:0] status;

    // The model of the object table, updated at the edge where a word is taken.
    bit          obj_valid [N_OBJ] = '{default: 1'b0};
    logic [63:0] obj_id    [N_OBJ];
    logic [63:0] obj_base  [N_OBJ];
    logic [63:0] obj_size  [N_OBJ];
    logic        obj_cls   [N_OBJ];
    logic [31:0] obj_stamp [N_OBJ];
    logic [31:0] alloc_count = '0;

    region_result_t awaited_results [$];
    obj_ref_t       issued_objs [$];
    int             mismatch_count = 0;

    object_region_classifier_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (cur_word.cmd),
        .obj_ident    (cur_word.id),
        .address      (cur_word.addr),
        .size         (cur_word.size),
        .region_class (cur_word.cls),
        .busy         (busy),
        .done         (done),
        .class_out    (class_out),
        .status       (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Applies one word to the table model and returns the result it must give.
    task automatic predict_region_word(input stim_row_t w, output logic exp_cls,
                                       output orc_pkg::status_t exp_st);
        int          i;
        int          slot;
        bit          hit;
        logic [31:0] best_age;
        logic [31:0] age;
        logic [64:0] span_end;
        exp_cls  = 1'b0;
        exp_st   = orc_pkg::STAT_OK;
        slot     = -1;
        hit      = 1'b0;
        best_age = '0;
        case (w.cmd)
            orc_pkg::CMD_ALLOC:
            begin
                // The range must end at or below the top of the address space.
                span_end = {1'b0, w.addr} + {1'b0, w.size};
                if (w.id == 0 || w.addr == 0 || w.size == 0 || span_end[64])
                    exp_st = orc_pkg::STAT_INVALID;
                else
                begin
                    for (i = 0; i < N_OBJ; i++)
                    begin
                        if (obj_valid[i])
                        begin
                            if (obj_id[i] == w.id)
                                exp_st = orc_pkg::STAT_DUP;
                        end
                        else if (slot < 0)
                            slot = i;
                    end
                    if (exp_st == orc_pkg::STAT_OK && slot < 0)
                        exp_st = orc_pkg::STAT_FULL;
                    else if (exp_st == orc_pkg::STAT_OK)
                    begin
                        obj_valid[slot] = 1'b1;
                        obj_id[slot]    = w.id;
                        obj_base[slot]  = w.addr;
                        obj_size[slot]  = w.size;
                        obj_cls[slot]   = w.cls;
                        obj_stamp[slot] = alloc_count;
                        alloc_count     = alloc_count + 32'd1;
                    end
                end
            end
            orc_pkg::CMD_FREE:
            begin
                exp_st = orc_pkg::STAT_NOMATCH;
                for (i = 0; i < N_OBJ && exp_st != orc_pkg::STAT_OK; i++)
                begin
                    if (obj_valid[i] && obj_id[i] == w.id && obj_base[i] == w.addr)
                    begin
                        obj_valid[i] = 1'b0;
                        exp_st       = orc_pkg::STAT_OK;
                    end
                end
            end
            orc_pkg::CMD_CLASSIFY:
            begin
                // The youngest covering object wins; age is modulo 2^32.
                for (i = 0; i < N_OBJ; i++)
                begin
                    if (obj_valid[i] && obj_base[i] <= w.addr &&
                        (w.addr - obj_base[i]) < obj_size[i])
                    begin
                        age = alloc_count - obj_stamp[i];
                        if (!hit || age < best_age)
                        begin
                            hit      = 1'b1;
                            best_age = age;
                            exp_cls  = obj_cls[i];
                        end
                    end
                end
            end
            default:
            begin
                obj_valid   = '{default: 1'b0};
                alloc_count = '0;
            end
        endcase
    endtask

    // Builds one random word. Most words are well formed and aimed at objects
    // that were allocated earlier; the rest are malformed, duplicate or noise.
    function automatic stim_row_t draw_random_word(input int alloc_pct, input int clear_pct);
        stim_row_t w;
        obj_ref_t  o;
        int        roll;
        int        kind;
        int        pick;
        w.id      = {$urandom(), $urandom()};
        w.addr    = {$urandom(), $urandom()};
        w.size    = {$urandom(), $urandom()};
        w.cls     = 1'($urandom_range(0, 1));
        w.pinned  = 1'b0;
        w.pin_cls = 1'b0;
        w.pin_st  = orc_pkg::STAT_OK;
        roll      = $urandom_range(0, 99);
        kind      = $urandom_range(0, 19);
        pick      = 0;
        if (roll < clear_pct)
        begin
            w.cmd = orc_pkg::CMD_CLEAR;
            issued_objs.delete();
        end
        else if (roll < clear_pct + alloc_pct)
        begin
            w.cmd = orc_pkg::CMD_ALLOC;
            if (kind >= 4)
                w.id = 64'($urandom_range(1, 160));
            if (kind == 1 && issued_objs.size() != 0)
            begin
                pick = $urandom_range(0, issued_objs.size() - 1);
                w.id = issued_objs[pick].id;
            end
            case (kind)
                0:
                begin
                    // One of the malformed shapes: zero id, zero base, zero
                    // size, or a range that runs past the top of memory.
                    case ($urandom_range(0, 3))
                        0: w.id = '0;
                        1: w.addr = '0;
                        2: w.size = '0;
                        default:
                        begin
                            w.addr = 64'hFFFF_FFFF_FFFF_F000 + $urandom_range(0, 4095);
                            w.size = 64'h1001 + $urandom_range(0, 65535);
                        end
                    endcase
                end
                2: ;
                3:
                begin
                    w.addr = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 8191);
                    w.size = 64'($urandom_range(1, 8192));
                end
                default:
                begin
                    w.addr = 64'h1_0000 + $urandom_range(0, 32767);
                    w.size = 64'($urandom_range(1, 8192));
                end
            endcase
            if (kind != 0)
            begin
                o.id   = w.id;
                o.base = w.addr;
                o.size = w.size;
                issued_objs = {issued_objs, o};
                if (issued_objs.size() > 96)
                    void'(issued_objs.pop_front());
            end
        end
        else if (roll < clear_pct + alloc_pct + (100 - clear_pct - alloc_pct) / 2)
        begin
            w.cmd = orc_pkg::CMD_FREE;
            if (issued_objs.size() != 0 && kind < 16)
            begin
                pick   = $urandom_range(0, issued_objs.size() - 1);
                o      = issued_objs[pick];
                w.id   = o.id;
                w.addr = (kind == 15) ? o.base + 64'd1 : o.base;
                issued_objs.delete(pick);
            end
            else if (kind < 18)
            begin
                w.id   = 64'($urandom_range(1, 160));
                w.addr = 64'h1_0000 + $urandom_range(0, 32767);
            end
        end
        else
        begin
            w.cmd = orc_pkg::CMD_CLASSIFY;
            if (issued_objs.size() != 0 && kind < 14)
            begin
                pick = $urandom_range(0, issued_objs.size() - 1);
                o    = issued_objs[pick];
                // Hit the first byte, the last byte, one past the end, or a
                // random byte inside the object.
                case (kind % 4)
                    0: w.addr = o.base;
                    1: w.addr = o.base + o.size - 64'd1;
                    2: w.addr = o.base + o.size;
                    default:
                        w.addr = (o.size != 0) ? o.base + ({$urandom(), $urandom()} % o.size)
                                               : o.base;
                endcase
            end
            else if (kind < 18)
                w.addr = 64'h1_0000 + $urandom_range(0, 40959);
        end
        return w;
    endfunction

    // Presents one word after an optional idle burst and returns at the edge
    // that takes it. Start stays high when the next word follows at once.
    task automatic send_word(input stim_row_t w, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cur_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Result check. A done strobe belongs to the oldest word in flight; it is
    // handled before a word taken at the same edge is entered.
    always @(posedge clk)
    begin : result_check
        region_result_t   oldest;
        region_result_t   fresh;
        logic             p_cls;
        orc_pkg::status_t p_st;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch("result strobe with no word outstanding");
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (class_out !== oldest.cls)
                        flag_mismatch($sformatf("class_out %b, expected %b",
                                                class_out, oldest.cls));
                    if (status !== oldest.st)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                status, oldest.st));
                end
            end
            if (start && !busy)
            begin
                predict_region_word(cur_word, p_cls, p_st);
                fresh.cls = cur_word.pinned ? cur_word.pin_cls : p_cls;
                fresh.st  = cur_word.pinned ? cur_word.pin_st : p_st;
                awaited_results = {awaited_results, fresh};
            end
        end
    end

    // Directed words: empty table, every malformed allocate, the top of the
    // address space, duplicate ids, overlapping objects where the younger one
    // wins, unmatched and double frees, an object covering almost all memory,
    // and a clear. Pinned rows carry their obvious result.
    stim_row_t directed_rows [$] = '{
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'd0, 64'd0, 1'b0,
          1'b1, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_ALLOC, 64'd0, 64'h1000, 64'd16, 1'b1,
          1'b1, 1'b0, orc_pkg::STAT_INVALID},
        '{orc_pkg::CMD_ALLOC, 64'd5, 64'd0, 64'd16, 1'b1,
          1'b1, 1'b0, orc_pkg::STAT_INVALID},
        '{orc_pkg::CMD_ALLOC, 64'd5, 64'h1000, 64'd0, 1'b1,
          1'b1, 1'b0, orc_pkg::STAT_INVALID},
        '{orc_pkg::CMD_ALLOC, 64'd5, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b1,
          1'b1, 1'b0, orc_pkg::STAT_INVALID},
        '{orc_pkg::CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 1'b1,
          1'b1, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 64'h40, 64'h10, 1'b0,
          1'b1, 1'b0, orc_pkg::STAT_DUP},
        '{orc_pkg::CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 1'b0,
          1'b1, 1'b0, orc_pkg::STAT_INVALID},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_ALLOC, 64'd1, 64'h1000, 64'h1000, 1'b1,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_ALLOC, 64'd2, 64'h1800, 64'h100, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'h1800, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'h18FF, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'h1900, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'h1FFF, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'h2000, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_FREE, 64'd2, 64'h1000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          1'b1, 1'b0, orc_pkg::STAT_NOMATCH},
        '{orc_pkg::CMD_FREE, 64'd2, 64'h1800, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          1'b1, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_FREE, 64'd2, 64'h1800, 64'd0, 1'b0,
          1'b1, 1'b0, orc_pkg::STAT_NOMATCH},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'h1800, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_ALLOC, 64'd3, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'd0, 64'd0, 1'b0,
          1'b0, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, orc_pkg::STAT_OK},
        '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'h1000, 64'd0, 1'b0,
          1'b1, 1'b0, orc_pkg::STAT_OK}
    };

    // Stimulus: reset, the directed rows, then random episodes of different
    // mixes. The first episode fills the table well past capacity; later ones
    // churn, lookup-heavy or with occasional clears.
    initial
    begin : stimulus
        stim_row_t w;
        int        sent;
        int        k;
        int        episode;
        int        span;
        int        gap;
        bit        idle_on;
        cur_word = '{orc_pkg::CMD_CLASSIFY, 64'd0, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0,
                     orc_pkg::STAT_OK};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_word(directed_rows[r], ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            episode = (sent == 0) ? 0 : $urandom_range(0, 3);
            span    = (episode == 0) ? $urandom_range(110, 160) : $urandom_range(40, 120);
            idle_on = ($urandom_range(0, 2) != 0);
            for (k = 0; k < span && sent < RANDOM_WORDS; k++)
            begin
                case (episode)
                    0: w = draw_random_word(90, 0);
                    1: w = draw_random_word(35, 2);
                    2: w = draw_random_word(45, 0);
                    default: w = draw_random_word(25, 1);
                endcase
                gap = 0;
                if (idle_on && sent < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 2) == 0)
                    gap = $urandom_range(1, 5);
                send_word(w, gap);
                sent++;
                // Halfway through, hold the sender until the block has
                // answered everything in flight.
                if (sent == RANDOM_WORDS / 2)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (awaited_results.size() != 0)
                        @(posedge clk);
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        // Leave room for a stray strobe after the last expected one.
        repeat (orc_pkg::MAX_OBJECTS_DEF + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog. A clean run needs under half a millisecond of simulated time,
    // table scans and idle bursts included.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
